>>> sv/crbs_pkg.sv
// types, constants and register codes shared by the resync scheduler files
`timescale 1ns / 1ps
`default_nettype none

package crbs_pkg;

  // smallest epoch that counts as a set wall clock
  localparam logic [31:0] MIN_VALID_EPOCH = 32'd1577836800;
  localparam logic [7:0]  FAIL_SAT        = 8'hFF;

  // event kinds
  localparam logic [2:0] MODE_POLL    = 3'd0;
  localparam logic [2:0] MODE_DONE    = 3'd1;
  localparam logic [2:0] MODE_PING    = 3'd2;
  localparam logic [2:0] MODE_MANUAL  = 3'd3;
  localparam logic [2:0] MODE_RESTORE = 3'd4;

  // configuration register indexes
  localparam int unsigned        CFG_IDX_W      = 3;
  localparam logic [CFG_IDX_W-1:0] REG_MANUAL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PING     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEADY   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RESYNC   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BO_FIRST = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BO_SEC   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BO_THIRD = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BO_LAST  = 3'd7;

  // configuration reset values
  localparam logic [31:0] STEADY_RST   = 32'd900000;
  localparam logic [31:0] RESYNC_RST   = 32'd82800;
  localparam logic [31:0] BO_FIRST_RST = 32'd30000;
  localparam logic [31:0] BO_SEC_RST   = 32'd60000;
  localparam logic [31:0] BO_THIRD_RST = 32'd120000;
  localparam logic [31:0] BO_LAST_RST  = 32'd300000;

  localparam int unsigned IN_DATA_W  = 104;
  localparam int unsigned OUT_DATA_W = 48;

  typedef struct packed {
    logic        manual_mode;
    logic        ping_autosync;
    logic [31:0] steady_interval_ms;
    logic [31:0] resync_interval_s;
    logic [31:0] backoff_first_ms;
    logic [31:0] backoff_second_ms;
    logic [31:0] backoff_third_ms;
    logic [31:0] backoff_last_ms;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic        wifi_connected;
    logic [31:0] now_ms;
    logic [31:0] now_epoch;
    logic [31:0] given_epoch;
    logic        task_ok;
  } in_item_t;

  typedef struct packed {
    logic        start_sync;
    logic        set_clock;
    logic [31:0] clock_value;
    logic        clock_trusted;
    logic [7:0]  failure_count;
  } out_item_t;

endpackage

`default_nettype wire

>>> sv/crbs_cfg_regs.sv
// configuration register file of the resync scheduler
`timescale 1ns / 1ps
`default_nettype none

module crbs_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          wr_en,
  input  wire logic [crbs_pkg::CFG_IDX_W-1:0] wr_index,
  input  wire logic [31:0]                   wr_data,
  output crbs_pkg::cfg_t                     cfg
);
  import crbs_pkg::*;

  // register writes, reset to the documented defaults
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.manual_mode        <= 1'b0;
      cfg.ping_autosync      <= 1'b0;
      cfg.steady_interval_ms <= STEADY_RST;
      cfg.resync_interval_s  <= RESYNC_RST;
      cfg.backoff_first_ms   <= BO_FIRST_RST;
      cfg.backoff_second_ms  <= BO_SEC_RST;
      cfg.backoff_third_ms   <= BO_THIRD_RST;
      cfg.backoff_last_ms    <= BO_LAST_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_MANUAL:   cfg.manual_mode        <= wr_data[0];
        REG_PING:     cfg.ping_autosync      <= wr_data[0];
        REG_STEADY:   cfg.steady_interval_ms <= wr_data;
        REG_RESYNC:   cfg.resync_interval_s  <= wr_data;
        REG_BO_FIRST: cfg.backoff_first_ms   <= wr_data;
        REG_BO_SEC:   cfg.backoff_second_ms  <= wr_data;
        REG_BO_THIRD: cfg.backoff_third_ms   <= wr_data;
        REG_BO_LAST:  cfg.backoff_last_ms    <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> sv/crbs_core.sv
// scheduler state and per-item decision logic
`timescale 1ns / 1ps
`default_nettype none

module crbs_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                fire,
  input  wire crbs_pkg::cfg_t      cfg,
  input  wire crbs_pkg::in_item_t  item,
  output crbs_pkg::out_item_t      result
);
  import crbs_pkg::*;

  logic [31:0] last_attempt_ms, last_attempt_ms_next;
  logic [31:0] last_ping_ms, last_ping_ms_next;
  logic [31:0] last_good_epoch, last_good_epoch_next;
  logic [7:0]  fail_streak, fail_streak_next;
  logic        link_was_up, link_was_up_next;
  logic        sync_busy, sync_busy_next;
  logic        sync_wanted, sync_wanted_next;
  logic        seed_untrusted, seed_untrusted_next;

  logic [31:0] retry_gap;
  logic [31:0] attempt_age;
  logic [31:0] ping_age;
  logic [31:0] good_age;
  logic        sync_due;
  logic        rising;
  logic        requested;
  logic        set_clk;
  logic [31:0] value;
  logic [31:0] clock_now;

  // backoff ladder on the failure streak
  always_comb begin
    case (fail_streak)
      8'd0:    retry_gap = cfg.steady_interval_ms;
      8'd1:    retry_gap = cfg.backoff_first_ms;
      8'd2:    retry_gap = cfg.backoff_second_ms;
      8'd3:    retry_gap = cfg.backoff_third_ms;
      default: retry_gap = cfg.backoff_last_ms;
    endcase
  end

  assign attempt_age = item.now_ms - last_attempt_ms;
  assign ping_age    = item.now_ms - last_ping_ms;
  assign good_age    = item.now_epoch - last_good_epoch;

  // due unless manual, or a trusted clock synced recently
  always_comb begin
    if (cfg.manual_mode)
      sync_due = 1'b0;
    else if (item.now_epoch < MIN_VALID_EPOCH || seed_untrusted || last_good_epoch == 32'd0)
      sync_due = 1'b1;
    else
      sync_due = !(item.now_epoch >= last_good_epoch && good_age < cfg.resync_interval_s);
  end

  assign rising    = item.wifi_connected && !link_was_up;
  assign requested = sync_wanted || rising;

  // next state and result for the current item
  always_comb begin
    last_attempt_ms_next = last_attempt_ms;
    last_ping_ms_next    = last_ping_ms;
    last_good_epoch_next = last_good_epoch;
    fail_streak_next     = fail_streak;
    link_was_up_next     = link_was_up;
    sync_busy_next       = sync_busy;
    sync_wanted_next     = sync_wanted;
    seed_untrusted_next  = seed_untrusted;
    result.start_sync    = 1'b0;
    set_clk              = 1'b0;
    value                = 32'd0;
    case (item.mode)
      MODE_POLL: begin
        link_was_up_next = item.wifi_connected;
        if (item.wifi_connected && !sync_busy) begin
          if (!requested && last_attempt_ms != 32'd0 && attempt_age < retry_gap) begin
            // still inside the retry gap
          end else if (!requested && !sync_due) begin
            last_attempt_ms_next = item.now_ms;
          end else begin
            sync_busy_next       = 1'b1;
            sync_wanted_next     = 1'b0;
            last_attempt_ms_next = item.now_ms;
            result.start_sync    = 1'b1;
          end
        end
      end
      MODE_DONE: begin
        if (sync_busy) begin
          sync_busy_next = 1'b0;
          if (item.task_ok) begin
            fail_streak_next = 8'd0;
            if (item.now_epoch >= MIN_VALID_EPOCH) begin
              last_good_epoch_next = item.now_epoch;
              seed_untrusted_next  = 1'b0;
            end
          end else if (fail_streak < FAIL_SAT) begin
            fail_streak_next = fail_streak + 8'd1;
          end
        end
      end
      MODE_PING: begin
        if (cfg.ping_autosync && item.wifi_connected && !sync_busy &&
            !(last_ping_ms != 32'd0 && ping_age < cfg.steady_interval_ms)) begin
          last_ping_ms_next = item.now_ms;
          sync_wanted_next  = 1'b1;
        end
      end
      MODE_MANUAL: begin
        set_clk              = 1'b1;
        value                = item.given_epoch;
        last_good_epoch_next = item.given_epoch;
        seed_untrusted_next  = 1'b0;
        fail_streak_next     = 8'd0;
      end
      MODE_RESTORE: begin
        if (item.now_epoch < MIN_VALID_EPOCH && item.given_epoch >= MIN_VALID_EPOCH) begin
          set_clk              = 1'b1;
          value                = item.given_epoch;
          last_good_epoch_next = item.given_epoch;
          seed_untrusted_next  = 1'b1;
        end
      end
      default: ;
    endcase
    clock_now            = set_clk ? value : item.now_epoch;
    result.set_clock     = set_clk;
    result.clock_value   = value;
    result.clock_trusted = (clock_now >= MIN_VALID_EPOCH) && !seed_untrusted_next;
    result.failure_count = fail_streak_next;
  end

  // state registers, updated once per item
  always_ff @(posedge clk) begin
    if (rst) begin
      last_attempt_ms <= 32'd0;
      last_ping_ms    <= 32'd0;
      last_good_epoch <= 32'd0;
      fail_streak     <= 8'd0;
      link_was_up     <= 1'b0;
      sync_busy       <= 1'b0;
      sync_wanted     <= 1'b0;
      seed_untrusted  <= 1'b0;
    end else if (fire) begin
      last_attempt_ms <= last_attempt_ms_next;
      last_ping_ms    <= last_ping_ms_next;
      last_good_epoch <= last_good_epoch_next;
      fail_streak     <= fail_streak_next;
      link_was_up     <= link_was_up_next;
      sync_busy       <= sync_busy_next;
      sync_wanted     <= sync_wanted_next;
      seed_untrusted  <= seed_untrusted_next;
    end
  end

endmodule

`default_nettype wire

>>> sv/clock_resync_backoff_scheduler.sv
// top level of the clock resync backoff scheduler
//
//  channel | direction | handshake              | content
//  s_*     | in        | s_tvalid / s_tready    | one event item, kind in s_tuser
//  m_*     | out       | m_tvalid / m_tready    | one decision item per event
//  cfg_*   | in        | cfg_valid / cfg_ready  | register index and write data
//
// an item is registered in the input register; the core decides on it combinationally and
// its result is registered in the result register, which drives m_*
// one item per cycle sustained while m_tready is high; state registers load with the result
// rst clears the pipeline valid flags, the scheduler state and the config registers
// a stalled output holds its item; the input register still takes one more item
// cfg_ready is always high; writes take effect on the next cycle
`timescale 1ns / 1ps
`default_nettype none

module clock_resync_backoff_scheduler (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output wire logic                              s_tready,
  // wifi_connected, now_ms, now_epoch, given_epoch, task_ok, zero fill
  input  wire logic [crbs_pkg::IN_DATA_W-1:0]    s_tdata,
  // mode
  input  wire logic [2:0]                        s_tuser,
  output wire logic                              m_tvalid,
  input  wire logic                              m_tready,
  // start_sync, set_clock, clock_value, clock_trusted, failure_count, zero fill
  output wire logic [crbs_pkg::OUT_DATA_W-1:0]   m_tdata,
  input  wire logic                              cfg_valid,
  output wire logic                              cfg_ready,
  input  wire logic [crbs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [31:0]                       cfg_data
);
  import crbs_pkg::*;

  cfg_t      cfg;
  in_item_t  in_item;
  in_item_t  s_item;
  out_item_t core_res;
  out_item_t out_item;
  logic      in_valid;
  logic      out_valid;
  logic      advance;

  assign cfg_ready = 1'b1;

  crbs_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // unpack the incoming item
  assign s_item.mode           = s_tuser;
  assign s_item.wifi_connected = s_tdata[0];
  assign s_item.now_ms         = s_tdata[32:1];
  assign s_item.now_epoch      = s_tdata[64:33];
  assign s_item.given_epoch    = s_tdata[96:65];
  assign s_item.task_ok        = s_tdata[97];

  // pipeline flow control
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item <= s_item;
    end
  end

  crbs_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .cfg    (cfg),
    .item   (in_item),
    .result (core_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= core_res;
    end
  end

  // pack the result item
  assign m_tvalid = out_valid;
  assign m_tdata  = {5'd0, out_item.failure_count, out_item.clock_trusted,
                     out_item.clock_value, out_item.set_clock, out_item.start_sync};

  // a poll never loads the clock, so both flags never show together
  a_start_excl_set: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_item.start_sync && out_item.set_clock))
    else $error("start_sync and set_clock both set");

  // no clock load means a zero clock value
  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_item.set_clock) |-> (out_item.clock_value == 32'd0))
    else $error("clock_value nonzero without set_clock");

  // reset empties both pipeline registers
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!in_valid && !out_valid))
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire
